// ===== rtl/core/rlce_pkg.sv =====
`default_nettype none
package rlce_pkg;

    localparam int NUM_LEDS     = 8;
    localparam int PALETTE_SIZE = 17;
    localparam int LED_W        = 3;
    localparam int LEVEL_W      = 16;
    localparam int PAL_W        = 10;
    localparam int DRIVE_W      = 12;
    localparam int DIM_W        = 8;

    localparam logic [2:0] MODE_RGB     = 3'd0;
    localparam logic [2:0] MODE_PALETTE = 3'd1;
    localparam logic [2:0] MODE_FADE    = 3'd2;
    localparam logic [2:0] MODE_BANK    = 3'd3;
    localparam logic [2:0] MODE_REFRESH = 3'd4;
    localparam logic [2:0] MODE_SHOW    = 3'd5;
    localparam logic [2:0] MODE_GAIN    = 3'd6;

    localparam logic REG_DIM  = 1'b0;
    localparam logic REG_SWAP = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic write_color;
        logic fade_step;
        logic write_gain;
        logic emit_pick;
        logic mul;
        logic clamp;
        logic div_step;
        logic load_out;
    } rlce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] mode;
        logic       op_ok;
        logic       any_changed;
        logic       fade_last;
        logic       div_done;
        logic       out_free;
    } rlce_sts_t;

    // Fixed palette ROM; entries past the table read as zero.
    function automatic logic [PAL_W-1:0] pal_level(input logic [4:0] idx,
                                                   input logic [1:0] ch);
        logic [3*PAL_W-1:0] row;
        row = '0;
        case (idx)
            5'd1:  row = {10'd930,  10'd950, 10'd900};
            5'd2:  row = {10'd1000, 10'd0,   10'd0};
            5'd3:  row = {10'd1000, 10'd200, 10'd0};
            5'd4:  row = {10'd700,  10'd650, 10'd0};
            5'd5:  row = {10'd0,    10'd600, 10'd60};
            5'd6:  row = {10'd0,    10'd560, 10'd1000};
            5'd7:  row = {10'd0,    10'd0,   10'd1000};
            5'd8:  row = {10'd1000, 10'd0,   10'd1000};
            5'd9:  row = {10'd410,  10'd0,   10'd1000};
            5'd10: row = {10'd150,  10'd150, 10'd200};
            5'd11: row = {10'd0,    10'd280, 10'd150};
            5'd12: row = {10'd550,  10'd700, 10'd0};
            5'd13: row = {10'd200,  10'd800, 10'd1000};
            5'd14: row = {10'd100,  10'd100, 10'd100};
            5'd15: row = {10'd50,   10'd0,   10'd0};
            5'd16: row = {10'd150,  10'd0,   10'd0};
            default: row = '0;
        endcase
        case (ch)
            2'd0:    pal_level = row[3*PAL_W-1:2*PAL_W];
            2'd1:    pal_level = row[2*PAL_W-1:PAL_W];
            2'd2:    pal_level = row[PAL_W-1:0];
            default: pal_level = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rlce_ctrl.sv =====
`default_nettype none
module rlce_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rlce_pkg::rlce_sts_t sts,
    output rlce_pkg::rlce_cmd_t     cmd
);
    import rlce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_FADE, S_SCAN, S_EMIT, S_MUL, S_CLAMP, S_DIV, S_OUT
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                if (sts.mode == MODE_REFRESH) begin
                    state_next = S_SCAN;
                end else if (sts.op_ok) begin
                    case (sts.mode)
                        MODE_RGB, MODE_PALETTE, MODE_BANK: cmd.write_color = 1'b1;
                        MODE_FADE:                         state_next = S_FADE;
                        MODE_SHOW:                         state_next = S_EMIT;
                        MODE_GAIN:                         cmd.write_gain = 1'b1;
                        default:                           state_next = S_IDLE;
                    endcase
                end
            end
            S_FADE: begin
                cmd.fade_step = 1'b1;
                if (sts.fade_last) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                state_next = sts.any_changed ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                cmd.emit_pick = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = (sts.mode == MODE_REFRESH) ? S_SCAN : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rlce_datapath.sv =====
`default_nettype none
module rlce_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rlce_pkg::rlce_cmd_t cmd,
    output rlce_pkg::rlce_sts_t      sts,
    input  wire logic                cfg_write,
    input  wire logic                cfg_index,
    input  wire logic [7:0]          cfg_data,
    input  wire logic [2:0]          s_mode,
    input  wire logic [2:0]          s_led,
    input  wire logic [15:0]         s_red,
    input  wire logic [15:0]         s_green,
    input  wire logic [15:0]         s_blue,
    input  wire logic [4:0]          s_palette_a,
    input  wire logic [4:0]          s_palette_b,
    input  wire logic [8:0]          s_fade,
    input  wire logic [7:0]          s_bank,
    input  wire logic [15:0]         s_timer,
    input  wire logic [1:0]          s_channel,
    input  wire logic [15:0]         s_gain,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [2:0]               m_led_out,
    output logic [11:0]              m_out_red,
    output logic [11:0]              m_out_green,
    output logic [11:0]              m_out_blue,
    output logic                     m_last
);
    import rlce_pkg::*;

    // captured input word
    logic [2:0]          mode_reg;
    logic [LED_W-1:0]    led_reg;
    logic [2:0][15:0]    rgb_reg;
    logic [4:0]          pa_reg, pb_reg;
    logic [8:0]          fade_reg;
    logic [7:0]          bank_reg;
    logic [15:0]         timer_reg;
    logic [1:0]          chan_reg;
    logic [15:0]         gain_in_reg;

    logic [DIM_W-1:0]    dim_reg;
    logic [7:0]          swap_reg;

    logic [2:0][LEVEL_W-1:0] color_reg [NUM_LEDS];
    logic [2:0][LEVEL_W-1:0] shown_reg [NUM_LEDS];
    logic [2:0][15:0]        gain_reg  [NUM_LEDS];

    logic [1:0]              fch_reg;
    logic [LED_W-1:0]        cur_reg;
    logic                    last_reg;
    logic [2:0][31:0]        prod_reg;
    logic [2:0][DRIVE_W-1:0] quot_reg;
    logic [2:0][DIM_W-1:0]   rem_reg;
    logic [3:0]              dcnt_reg;

    logic                    m_valid_reg;
    logic [2:0]              m_led_reg;
    logic [2:0][DRIVE_W-1:0] m_drv_reg;
    logic                    m_last_reg;

    // operand checks
    logic       led_ok, pa_ok, pb_ok, bank_ok, op_ok;
    logic [2:0] blinks;
    logic [7:0] bank_rem;
    logic       dark, win_hit;
    logic [2:0] win_k;
    logic [4:0] pal_idx;

    assign led_ok  = ({1'b0, led_reg} < 4'(NUM_LEDS));
    assign pa_ok   = ({2'b0, pa_reg} < 7'(PALETTE_SIZE));
    assign pb_ok   = ({2'b0, pb_reg} < 7'(PALETTE_SIZE));
    assign bank_ok = (bank_reg <= 8'd59);

    always_comb begin
        if (bank_reg >= 8'd50)      blinks = 3'd5;
        else if (bank_reg >= 8'd40) blinks = 3'd4;
        else if (bank_reg >= 8'd30) blinks = 3'd3;
        else if (bank_reg >= 8'd20) blinks = 3'd2;
        else if (bank_reg >= 8'd10) blinks = 3'd1;
        else                        blinks = 3'd0;
        bank_rem = bank_reg - 8'(blinks * 4'd10);
        // dark windows start every 0x3000 ticks and last 0x1000
        win_hit = 1'b1;
        case (timer_reg[15:12])
            4'd0:    win_k = 3'd0;
            4'd3:    win_k = 3'd1;
            4'd6:    win_k = 3'd2;
            4'd9:    win_k = 3'd3;
            4'd12:   win_k = 3'd4;
            4'd15:   win_k = 3'd5;
            default: begin
                win_k   = 3'd0;
                win_hit = 1'b0;
            end
        endcase
        dark    = win_hit && (win_k < blinks);
        pal_idx = (mode_reg == MODE_BANK) ? (dark ? 5'd0 : 5'(bank_rem + 8'd1)) : pa_reg;
        case (mode_reg)
            MODE_RGB:     op_ok = led_ok;
            MODE_PALETTE: op_ok = led_ok && pa_ok;
            MODE_FADE:    op_ok = led_ok && pa_ok && pb_ok;
            MODE_BANK:    op_ok = led_ok && bank_ok && ({2'b0, pal_idx} < 7'(PALETTE_SIZE));
            MODE_SHOW:    op_ok = led_ok;
            MODE_GAIN:    op_ok = led_ok && (chan_reg != 2'd3);
            default:      op_ok = 1'b0;
        endcase
    end

    // one fade channel per step
    logic [8:0]         fsat;
    logic [PAL_W-1:0]   fa, fb;
    logic [17:0]        fsum;
    assign fsat = (fade_reg > 9'd256) ? 9'd256 : fade_reg;
    assign fa   = pal_level(pa_reg, fch_reg);
    assign fb   = pal_level(pb_reg, fch_reg);
    assign fsum = 18'(fa * (9'd256 - fsat)) + 18'(fb * fsat);

    // changed LEDs and lowest pick
    logic [NUM_LEDS-1:0] changed;
    logic [LED_W-1:0]    low_idx;
    logic                multi_chg;
    logic [LED_W-1:0]    pick_idx;

    always_comb begin
        low_idx = '0;
        for (int i = NUM_LEDS - 1; i >= 0; i--) begin
            changed[i] = (color_reg[i] != shown_reg[i]);
            if (changed[i]) begin
                low_idx = LED_W'(i);
            end
        end
        multi_chg = |(changed & (changed - NUM_LEDS'(1)));
        pick_idx  = (mode_reg == MODE_REFRESH) ? low_idx : led_reg;
    end

    // divider lanes: one quotient bit per step
    logic [2:0][8:0]         trial;
    logic [2:0]              ge;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            trial[c] = {rem_reg[c], quot_reg[c][DRIVE_W-1]};
            ge[c]    = (trial[c] >= {1'b0, dim_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg    <= s_mode;
            led_reg     <= s_led;
            rgb_reg     <= {s_blue, s_green, s_red};
            pa_reg      <= s_palette_a;
            pb_reg      <= s_palette_b;
            fade_reg    <= s_fade;
            bank_reg    <= s_bank;
            timer_reg   <= s_timer;
            chan_reg    <= s_channel;
            gain_in_reg <= s_gain;
        end
        if (cmd.emit_pick) begin
            cur_reg  <= pick_idx;
            last_reg <= (mode_reg == MODE_REFRESH) ? !multi_chg : 1'b1;
        end
        if (cmd.mul) begin
            for (int c = 0; c < 3; c++) begin
                prod_reg[c] <= shown_reg[cur_reg][c] * gain_reg[cur_reg][c];
            end
        end
        if (cmd.clamp) begin
            for (int c = 0; c < 3; c++) begin
                quot_reg[c] <= (prod_reg[c][31:22] != '0) ? {DRIVE_W{1'b1}}
                                                          : prod_reg[c][21:10];
                rem_reg[c]  <= '0;
            end
            dcnt_reg <= (dim_reg == '0) ? 4'd0 : 4'(DRIVE_W);
        end else if (cmd.div_step) begin
            for (int c = 0; c < 3; c++) begin
                rem_reg[c]  <= ge[c] ? 8'(trial[c] - {1'b0, dim_reg}) : trial[c][7:0];
                quot_reg[c] <= {quot_reg[c][DRIVE_W-2:0], ge[c]};
            end
            dcnt_reg <= dcnt_reg - 4'd1;
        end
        if (cmd.load_out) begin
            m_led_reg    <= cur_reg;
            m_drv_reg[0] <= quot_reg[0];
            m_drv_reg[1] <= swap_reg[cur_reg] ? quot_reg[2] : quot_reg[1];
            m_drv_reg[2] <= swap_reg[cur_reg] ? quot_reg[1] : quot_reg[2];
            m_last_reg   <= last_reg;
        end
    end

    // state with defined reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                for (int c = 0; c < 3; c++) begin
                    color_reg[i][c] <= '0;
                    shown_reg[i][c] <= 16'h00FF;
                    gain_reg[i][c]  <= 16'd4096;
                end
            end
            dim_reg     <= '0;
            swap_reg    <= '0;
            fch_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_DIM:  dim_reg  <= cfg_data;
                    REG_SWAP: swap_reg <= cfg_data;
                    default:  dim_reg  <= dim_reg;
                endcase
            end
            if (cmd.write_color) begin
                for (int c = 0; c < 3; c++) begin
                    color_reg[led_reg][c] <= (mode_reg == MODE_RGB) ? rgb_reg[c]
                        : 16'(pal_level(pal_idx, 2'(c)));
                end
            end
            if (cmd.load_in) begin
                fch_reg <= '0;
            end else if (cmd.fade_step) begin
                color_reg[led_reg][fch_reg] <= 16'(fsum[17:8]);
                fch_reg <= fch_reg + 2'd1;
            end
            if (cmd.write_gain) begin
                gain_reg[led_reg][chan_reg] <= gain_in_reg;
            end
            if (cmd.emit_pick) begin
                shown_reg[pick_idx] <= color_reg[pick_idx];
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.mode        = mode_reg;
    assign sts.op_ok       = op_ok;
    assign sts.any_changed = |changed;
    assign sts.fade_last   = (fch_reg == 2'd2);
    assign sts.div_done    = (dcnt_reg == 4'd0);
    assign sts.out_free    = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_led_out   = m_led_reg;
    assign m_out_red   = m_drv_reg[0];
    assign m_out_green = m_drv_reg[1];
    assign m_out_blue  = m_drv_reg[2];
    assign m_last      = m_last_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rgb_led_color_engine_core.sv =====
// Channel   Direction  Handshake          Word
// s_*       in         s_valid/s_ready    one command (mode, led, levels, palette, gain)
// m_*       out        m_valid/m_ready    one LED drive word (led_out, r/g/b, last)
// cfg_*     in         cfg_write          register write (0 dim divisor, 1 swap mask)
//
// Commands that emit nothing return to idle after decode; a fade writes one channel
// per step. Each emitted word passes pick, multiply, clamp and the 12-step divider
// loop (skipped when the dim divisor is zero); a show emits one word, and a refresh
// emits each changed LED, with one scan per word plus a final scan.
// Input is taken only while the controller is idle; a finished word waits in the
// output register, so a stalled m_ready holds only the next emitted word.
// aresetn is synchronous and active low; colors, shown copies and gains reset at once.
`default_nettype none
module rgb_led_color_engine_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_mode,
    input  wire logic [2:0]  s_led,
    input  wire logic [15:0] s_red,
    input  wire logic [15:0] s_green,
    input  wire logic [15:0] s_blue,
    input  wire logic [4:0]  s_palette_a,
    input  wire logic [4:0]  s_palette_b,
    input  wire logic [8:0]  s_fade,
    input  wire logic [7:0]  s_bank,
    input  wire logic [15:0] s_timer,
    input  wire logic [1:0]  s_channel,
    input  wire logic [15:0] s_gain,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_led_out,
    output logic [11:0]      m_out_red,
    output logic [11:0]      m_out_green,
    output logic [11:0]      m_out_blue,
    output logic             m_last
);
    import rlce_pkg::*;

    rlce_cmd_t cmd;
    rlce_sts_t sts;

    // Sequence each command: decode, then fade steps or emit passes.
    rlce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold colors, gains and registers; scale and divide drive values.
    rlce_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_mode      (s_mode),
        .s_led       (s_led),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .s_palette_a (s_palette_a),
        .s_palette_b (s_palette_b),
        .s_fade      (s_fade),
        .s_bank      (s_bank),
        .s_timer     (s_timer),
        .s_channel   (s_channel),
        .s_gain      (s_gain),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_led_out   (m_led_out),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_last      (m_last)
    );

endmodule
`default_nettype wire

// ===== rtl/core/rlce_checker.sv =====
`default_nettype none
module rlce_sva (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_led_out,
    input wire logic [11:0] m_out_red,
    input wire logic        m_last
);

    // stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_out) && $stable(m_out_red)
                                && $stable(m_last))
        else $error("output word changed while stalled");

    // no word right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // one command at a time
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on back-to-back cycles");

    // a word never appears the cycle after a command is taken
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("output word appeared too early");

endmodule

bind rgb_led_color_engine_core rlce_sva u_rlce_sva (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_led_out (m_led_out),
    .m_out_red (m_out_red),
    .m_last    (m_last)
);
`default_nettype wire
